// File: rtl/core/histogram_peak_segmenter_top_assert.svh
// assertion macros for the histogram peak segmenter
`ifndef HISTOGRAM_PEAK_SEGMENTER_TOP_ASSERT_SVH
`define HISTOGRAM_PEAK_SEGMENTER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define HPS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hps assertion failed");
`define HPS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hps assertion failed");
`else
`define HPS_ASSERT_IMP(name, ante, cons)
`define HPS_ASSERT_NXT(name, ante, cons)
`endif
`endif

// File: rtl/core/hps_pkg.sv
// types and constants shared by the histogram peak segmenter
package hps_pkg;

	localparam int POS_W     = 17;
	localparam int CNT_W     = 32;
	localparam int PEAKS_W   = 10;
	localparam int CFG_IDX_W = 3;
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = 2;
	localparam int OUTQ_CNT_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_THR    = 3'd0,
		REG_MID_THR    = 3'd1,
		REG_UPPER_THR  = 3'd2,
		REG_MAX_PEAKS  = 3'd3,
		REG_COUNT_ZERO = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		KIND_PEAK    = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	localparam logic [CNT_W-1:0]   LOW_THR_RST    = 32'd5;
	localparam logic [CNT_W-1:0]   MID_THR_RST    = 32'd16;
	localparam logic [CNT_W-1:0]   UPPER_THR_RST  = 32'h7FFF_FFFF;
	localparam logic [PEAKS_W-1:0] MAX_PEAKS_RST  = 10'd48;
	localparam logic               COUNT_ZERO_RST = 1'b0;

	typedef struct packed {
		logic [CNT_W-1:0]   low_thr;
		logic [CNT_W-1:0]   mid_thr;
		logic [CNT_W-1:0]   upper_thr;
		logic [PEAKS_W-1:0] max_peaks;
		logic               count_zero;
	} cfg_t;

	typedef struct packed {
		logic               kind;
		logic [POS_W-1:0]   peak_lower;
		logic [POS_W-1:0]   peak_upper;
		logic [POS_W-1:0]   peak_position;
		logic [CNT_W-1:0]   peak_value;
		logic [PEAKS_W-1:0] peaks_found;
		logic               truncated;
		logic [POS_W-1:0]   widest_width;
		logic [POS_W-1:0]   widest_upper;
		logic [POS_W-1:0]   first_nonzero;
		logic               last;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       a;
		res_t       b;
	} push_t;

endpackage

// File: rtl/core/hps_if.sv
// valid/ready channel interfaces for bins and results
interface hps_bin_if;
	logic                      valid;
	logic                      ready;
	logic [hps_pkg::CNT_W-1:0] bin_count;
	logic                      last_bin;

	modport source (output valid, output bin_count, output last_bin, input ready);
	modport sink (input valid, input bin_count, input last_bin, output ready);
endinterface

interface hps_res_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [hps_pkg::POS_W-1:0]   peak_lower;
	logic [hps_pkg::POS_W-1:0]   peak_upper;
	logic [hps_pkg::POS_W-1:0]   peak_position;
	logic [hps_pkg::CNT_W-1:0]   peak_value;
	logic [hps_pkg::PEAKS_W-1:0] peaks_found;
	logic                        truncated;
	logic [hps_pkg::POS_W-1:0]   widest_width;
	logic [hps_pkg::POS_W-1:0]   widest_upper;
	logic [hps_pkg::POS_W-1:0]   first_nonzero;
	logic                        last;

	modport source (output valid, output kind, output peak_lower, output peak_upper,
		output peak_position, output peak_value, output peaks_found, output truncated,
		output widest_width, output widest_upper, output first_nonzero, output last,
		input ready);
	modport sink (input valid, input kind, input peak_lower, input peak_upper,
		input peak_position, input peak_value, input peaks_found, input truncated,
		input widest_width, input widest_upper, input first_nonzero, input last,
		output ready);
endinterface

// File: rtl/core/hps_cfg.sv
// configuration register file
module hps_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hps_pkg::CNT_W-1:0]      cfg_data,
	output hps_pkg::cfg_t                  cfg
);
	import hps_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_thr    <= LOW_THR_RST;
			cfg_q.mid_thr    <= MID_THR_RST;
			cfg_q.upper_thr  <= UPPER_THR_RST;
			cfg_q.max_peaks  <= MAX_PEAKS_RST;
			cfg_q.count_zero <= COUNT_ZERO_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOW_THR:    cfg_q.low_thr    <= cfg_data;
				REG_MID_THR:    cfg_q.mid_thr    <= cfg_data;
				REG_UPPER_THR:  cfg_q.upper_thr  <= cfg_data;
				REG_MAX_PEAKS:  cfg_q.max_peaks  <= cfg_data[PEAKS_W-1:0];
				REG_COUNT_ZERO: cfg_q.count_zero <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// File: rtl/core/hps_core.sv
// input register and per-bin hill, run and summary tracking
module hps_core #(
	parameter int MAX_BINS   = 65536,
	parameter int PEAK_LIMIT = 1023
) (
	input  logic            clk,
	input  logic            arst_n,
	hps_bin_if.sink         hist,
	input  hps_pkg::cfg_t   cfg,
	input  logic            room,
	output hps_pkg::push_t  push
);
	import hps_pkg::*;

	localparam int BIN_W = $clog2(MAX_BINS + 1);

	logic             s1_valid_q;
	logic [CNT_W-1:0] count_s1;
	logic             last_s1;
	logic             commit;

	logic [BIN_W-1:0]   idx_q, hstart_q, bpos_q, rstart_q, rwidest_q, rlast_q, first_q;
	logic [CNT_W-1:0]   bval_q;
	logic [PEAKS_W-1:0] peaks_q;
	logic               hopen_q, over_q, ropen_q, nzseen_q;

	logic [BIN_W-1:0]   idx_n, hstart_n, bpos_n, rstart_n, rwidest_n, rlast_n, first_n;
	logic [CNT_W-1:0]   bval_n;
	logic [PEAKS_W-1:0] peaks_n;
	logic               hopen_n, over_n, ropen_n, nzseen_n;

	logic [PEAKS_W-1:0] limit;
	logic               full, in_range, nz;
	logic [CNT_W-1:0]   v;
	logic [BIN_W-1:0]   run_w;
	logic               rec_valid;
	res_t               rec, sum;

	assign commit     = s1_valid_q && room;
	assign hist.ready = !s1_valid_q || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (hist.valid && hist.ready) begin
			s1_valid_q <= 1'b1;
		end else if (commit) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hist.valid && hist.ready) begin
			count_s1 <= hist.bin_count;
			last_s1  <= hist.last_bin;
		end
	end

	assign limit = (cfg.max_peaks < PEAKS_W'(PEAK_LIMIT)) ? cfg.max_peaks
		: PEAKS_W'(PEAK_LIMIT);
	assign full     = peaks_q >= limit;
	assign in_range = idx_q < BIN_W'(MAX_BINS);
	assign v        = (idx_q == '0 && !cfg.count_zero) ? '0 : count_s1;
	assign nz       = v != '0;
	assign run_w    = idx_q - rstart_q;

	always_comb begin
		idx_n     = idx_q;
		hstart_n  = hstart_q;
		bpos_n    = bpos_q;
		bval_n    = bval_q;
		hopen_n   = hopen_q;
		over_n    = over_q;
		peaks_n   = peaks_q;
		ropen_n   = ropen_q;
		rstart_n  = rstart_q;
		rwidest_n = rwidest_q;
		rlast_n   = rlast_q;
		first_n   = first_q;
		nzseen_n  = nzseen_q;
		rec_valid = 1'b0;
		rec       = '0;
		sum       = '0;

		if (in_range) begin
			if (nz && !nzseen_q) begin
				first_n  = idx_q;
				nzseen_n = 1'b1;
			end
			if (!full) begin
				if (nz && !ropen_q) begin
					ropen_n  = 1'b1;
					rstart_n = idx_q;
				end else if (!nz && ropen_q) begin
					rlast_n = idx_q;
					if (run_w > rwidest_q) begin
						rwidest_n = run_w;
					end
					ropen_n = 1'b0;
				end
				if (v > cfg.low_thr) begin
					if (!hopen_q) begin
						hopen_n  = 1'b1;
						hstart_n = idx_q;
					end
					if (v > cfg.upper_thr) begin
						over_n = 1'b1;
					end
					if (v > cfg.mid_thr && v > bval_q) begin
						bpos_n = idx_q;
						bval_n = v;
					end
				end else if (hopen_q) begin
					if (bval_q != '0 && !over_q) begin
						rec_valid         = 1'b1;
						rec.peak_lower    = POS_W'(hstart_q);
						rec.peak_upper    = POS_W'(idx_q);
						rec.peak_position = POS_W'(bpos_q);
						rec.peak_value    = bval_q;
						peaks_n           = peaks_q + 1'b1;
					end
					hopen_n  = 1'b0;
					hstart_n = '0;
					bpos_n   = '0;
					bval_n   = '0;
					over_n   = 1'b0;
				end
			end
			idx_n = idx_q + 1'b1;
		end

		if (last_s1) begin
			// close a hill still open at the end
			if (!full && hopen_n && bval_n != '0) begin
				rec_valid         = 1'b1;
				rec.peak_lower    = POS_W'(hstart_n);
				rec.peak_upper    = POS_W'(idx_n);
				rec.peak_position = POS_W'(bpos_n);
				rec.peak_value    = bval_n;
				peaks_n           = peaks_n + 1'b1;
			end
			sum.kind          = KIND_SUMMARY;
			sum.peaks_found   = peaks_n;
			sum.truncated     = full;
			sum.widest_width  = POS_W'(rwidest_n);
			sum.widest_upper  = POS_W'(rlast_n);
			sum.first_nonzero = POS_W'(first_n);
			sum.last          = 1'b1;
			idx_n     = '0;
			hstart_n  = '0;
			bpos_n    = '0;
			bval_n    = '0;
			hopen_n   = 1'b0;
			over_n    = 1'b0;
			peaks_n   = '0;
			ropen_n   = 1'b0;
			rstart_n  = '0;
			rwidest_n = '0;
			rlast_n   = '0;
			first_n   = '0;
			nzseen_n  = 1'b0;
		end
		rec.kind = KIND_PEAK;
		rec.last = !last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			hstart_q  <= '0;
			bpos_q    <= '0;
			bval_q    <= '0;
			hopen_q   <= 1'b0;
			over_q    <= 1'b0;
			peaks_q   <= '0;
			ropen_q   <= 1'b0;
			rstart_q  <= '0;
			rwidest_q <= '0;
			rlast_q   <= '0;
			first_q   <= '0;
			nzseen_q  <= 1'b0;
		end else if (commit) begin
			idx_q     <= idx_n;
			hstart_q  <= hstart_n;
			bpos_q    <= bpos_n;
			bval_q    <= bval_n;
			hopen_q   <= hopen_n;
			over_q    <= over_n;
			peaks_q   <= peaks_n;
			ropen_q   <= ropen_n;
			rstart_q  <= rstart_n;
			rwidest_q <= rwidest_n;
			rlast_q   <= rlast_n;
			first_q   <= first_n;
			nzseen_q  <= nzseen_n;
		end
	end

	always_comb begin
		push.cnt = '0;
		if (commit) begin
			push.cnt = {1'b0, rec_valid} + {1'b0, last_s1};
		end
		push.a = rec_valid ? rec : sum;
		push.b = sum;
	end
endmodule

// File: rtl/core/hps_outq.sv
// result queue that takes up to two results per cycle
module hps_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  hps_pkg::push_t  push,
	output logic            room,
	hps_res_if.source       seg
);
	import hps_pkg::*;

	res_t                  mem_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wr_q, rd_q;
	logic [OUTQ_CNT_W-1:0] count_q;
	logic                  pop;
	res_t                  head;

	assign room = count_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
	assign pop  = seg.valid && seg.ready;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.a;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_q + 1'b1] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + OUTQ_PTR_W'(push.cnt);
			rd_q    <= rd_q + OUTQ_PTR_W'(pop);
			count_q <= count_q + OUTQ_CNT_W'(push.cnt) - OUTQ_CNT_W'(pop);
		end
	end

	assign head              = mem_q[rd_q];
	assign seg.valid         = count_q != '0;
	assign seg.kind          = head.kind;
	assign seg.peak_lower    = head.peak_lower;
	assign seg.peak_upper    = head.peak_upper;
	assign seg.peak_position = head.peak_position;
	assign seg.peak_value    = head.peak_value;
	assign seg.peaks_found   = head.peaks_found;
	assign seg.truncated     = head.truncated;
	assign seg.widest_width  = head.widest_width;
	assign seg.widest_upper  = head.widest_upper;
	assign seg.first_nonzero = head.first_nonzero;
	assign seg.last          = head.last;
endmodule

// File: rtl/core/histogram_peak_segmenter_top.sv
// top level of the histogram peak segmenter
//
// channel  | role | handshake        | payload
// hist     | in   | valid/ready      | bin_count, last_bin
// seg      | out  | valid/ready      | peak record or end-of-histogram summary
// cfg      | in   | write enable     | cfg_index, cfg_data
//
// one bin per cycle while the queue has room: an input register, compare and
// update logic, then a four-entry result queue
// a bin leaves the input register while the queue holds at most two results;
// a last bin may push two
// a bin's first result is written to the queue when it leaves the input register
// reset clears all tracking state and loads the register defaults
module histogram_peak_segmenter_top #(
	parameter int MAX_BINS   = 65536,
	parameter int PEAK_LIMIT = 1023
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hps_pkg::CNT_W-1:0]     cfg_data,
	hps_bin_if.sink                       hist,
	hps_res_if.source                     seg
);
	import hps_pkg::*;

	`include "histogram_peak_segmenter_top_assert.svh"

	cfg_t  cfg;
	push_t push;
	logic  room;

	hps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hps_core #(
		.MAX_BINS   (MAX_BINS),
		.PEAK_LIMIT (PEAK_LIMIT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.hist   (hist),
		.cfg    (cfg),
		.room   (room),
		.push   (push)
	);

	hps_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.seg    (seg)
	);

	`HPS_ASSERT_IMP(a_summary_is_last, seg.valid && seg.kind, seg.last)
	`HPS_ASSERT_IMP(a_peak_span, seg.valid && !seg.kind, seg.peak_upper > seg.peak_lower)
	`HPS_ASSERT_IMP(a_pair_order, push.cnt == 2'd2, push.b.kind && !push.a.kind && push.b.last)
	`HPS_ASSERT_NXT(a_pair_visible, push.cnt == 2'd2, seg.valid)
endmodule
